/* src/mrfc_pkg.sv */
// Shared constants, types and the CRC-16/Modbus byte update for the response checker.
`timescale 1ns / 1ps

package mrfc_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned WORD_W    = 16;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned CSR_IDX_W = 8;

   localparam logic [COUNT_W-1:0] FRAME_BYTES = COUNT_W'(9);
   localparam logic [COUNT_W-1:0] CRC_SPAN    = COUNT_W'(7);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(15);

   localparam logic [COUNT_W-1:0] POS_ADDRESS  = COUNT_W'(0);
   localparam logic [COUNT_W-1:0] POS_FUNCTION = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] POS_SPEED_HI = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] POS_SPEED_LO = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] POS_GRADE_HI = COUNT_W'(5);
   localparam logic [COUNT_W-1:0] POS_GRADE_LO = COUNT_W'(6);
   localparam logic [COUNT_W-1:0] POS_CRC_LO   = COUNT_W'(7);
   localparam logic [COUNT_W-1:0] POS_CRC_HI   = COUNT_W'(8);

   localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

   localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RESET = 8'h01;
   localparam logic [BYTE_W-1:0] FUNCTION_CODE_RESET  = 8'h03;

   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FUNCTION_CODE  = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_LENGTH = 2'd1,
      STATUS_HEADER = 2'd2,
      STATUS_CRC    = 2'd3
   } status_type;

   function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] c;
      c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* src/mrfc_if.sv */
// Valid/ready channel interfaces for frame bytes, check results and register writes.
`timescale 1ns / 1ps

interface mrfc_req_if import mrfc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrfc_rsp_if import mrfc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [WORD_W-1:0] wind_speed;
   logic [WORD_W-1:0] wind_level;

   modport source (output valid, output status, output wind_speed, output wind_level,
                   input ready);
   modport sink   (input valid, input status, input wind_speed, input wind_level,
                   output ready);
endinterface

interface mrfc_csr_if import mrfc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/modbus_response_frame_checker.sv */
// Modbus RTU read-response checker: byte intake, CRC-16/Modbus, header and length check.
//
// Usage:
//   req_if carries one frame byte per transaction, with frame_end set on the last byte.
//   rsp_if carries one result per frame: status (0 ok, 1 length, 2 address or function,
//   3 CRC), wind_speed and wind_level; both values read 0 unless status is ok.
//   csr_if writes device_address (index 0) and function_code (index 1); other indexes
//   are ignored. Writes are always taken and belong between frames.
// Timing:
//   One byte per cycle while req_if.ready is high. The result of a frame appears on rsp_if
//   in the cycle after its last byte is taken; the byte update, the CRC step and the final
//   compares sit between the frame state registers and the result register.
// Reset:
//   Synchronous, active high. Clears the frame state, restores both registers to their
//   defaults (address 1, function code 3) and empties the result register.
// Stall:
//   While a result waits and rsp_if.ready is low, req_if.ready drops; it stays high when
//   the waiting result is taken in the same cycle.
`timescale 1ns / 1ps

module modbus_response_frame_checker import mrfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   mrfc_req_if.sink   req_if,
   mrfc_rsp_if.source rsp_if,
   mrfc_csr_if.sink   csr_if
);

   logic [BYTE_W-1:0]  device_address_ff, device_address_in;
   logic [BYTE_W-1:0]  function_code_ff, function_code_in;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [WORD_W-1:0]  running_crc_ff, running_crc_in;
   logic               header_ok_ff, header_ok_in;
   logic [WORD_W-1:0]  speed_hold_ff, speed_hold_in;
   logic [WORD_W-1:0]  grade_hold_ff, grade_hold_in;
   logic [WORD_W-1:0]  crc_hold_ff, crc_hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]  rsp_speed_ff, rsp_speed_in;
   logic [WORD_W-1:0]  rsp_grade_ff, rsp_grade_in;

   logic               req_take;
   logic               rsp_take;
   logic               csr_take;
   logic [COUNT_W-1:0] count_next;
   logic [WORD_W-1:0]  crc_next;
   logic               header_next;
   logic [WORD_W-1:0]  speed_next;
   logic [WORD_W-1:0]  grade_next;
   logic [WORD_W-1:0]  hold_next;
   status_type         status_next;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready = 1'b1;
   assign req_take     = req_if.valid && req_if.ready;
   assign rsp_take     = rsp_valid_ff && rsp_if.ready;
   assign csr_take     = csr_if.valid && csr_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.wind_speed = rsp_speed_ff;
   assign rsp_if.wind_level = rsp_grade_ff;

   always_comb begin
      device_address_in = device_address_ff;
      function_code_in  = function_code_ff;
      if (csr_take) begin
         case (csr_if.index)
            CSR_DEVICE_ADDRESS: device_address_in = csr_if.data;
            CSR_FUNCTION_CODE:  function_code_in  = csr_if.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      header_next = header_ok_ff;
      if (byte_count_ff == POS_ADDRESS && req_if.rx_byte != device_address_ff) begin
         header_next = 1'b0;
      end
      if (byte_count_ff == POS_FUNCTION && req_if.rx_byte != function_code_ff) begin
         header_next = 1'b0;
      end

      crc_next = running_crc_ff;
      if (byte_count_ff < CRC_SPAN) begin
         crc_next = crc16_byte(running_crc_ff, req_if.rx_byte);
      end

      speed_next = speed_hold_ff;
      grade_next = grade_hold_ff;
      hold_next  = crc_hold_ff;
      case (byte_count_ff)
         POS_SPEED_HI: speed_next = {req_if.rx_byte, speed_hold_ff[BYTE_W-1:0]};
         POS_SPEED_LO: speed_next = {speed_hold_ff[WORD_W-1:BYTE_W], req_if.rx_byte};
         POS_GRADE_HI: grade_next = {req_if.rx_byte, grade_hold_ff[BYTE_W-1:0]};
         POS_GRADE_LO: grade_next = {grade_hold_ff[WORD_W-1:BYTE_W], req_if.rx_byte};
         POS_CRC_LO:   hold_next  = {crc_hold_ff[WORD_W-1:BYTE_W], req_if.rx_byte};
         POS_CRC_HI:   hold_next  = {req_if.rx_byte, crc_hold_ff[BYTE_W-1:0]};
         default: ;
      endcase

      count_next = (byte_count_ff < COUNT_MAX) ? byte_count_ff + COUNT_W'(1) : byte_count_ff;

      if (count_next != FRAME_BYTES) begin
         status_next = STATUS_LENGTH;
      end else if (!header_next) begin
         status_next = STATUS_HEADER;
      end else if (crc_next != hold_next) begin
         status_next = STATUS_CRC;
      end else begin
         status_next = STATUS_OK;
      end
   end

   always_comb begin
      byte_count_in  = byte_count_ff;
      running_crc_in = running_crc_ff;
      header_ok_in   = header_ok_ff;
      speed_hold_in  = speed_hold_ff;
      grade_hold_in  = grade_hold_ff;
      crc_hold_in    = crc_hold_ff;
      rsp_valid_in   = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_speed_in   = rsp_speed_ff;
      rsp_grade_in   = rsp_grade_ff;
      if (req_take) begin
         if (req_if.frame_end) begin
            byte_count_in  = '0;
            running_crc_in = CRC_INIT;
            header_ok_in   = 1'b1;
            speed_hold_in  = '0;
            grade_hold_in  = '0;
            crc_hold_in    = '0;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = status_next;
            rsp_speed_in   = (status_next == STATUS_OK) ? speed_next : '0;
            rsp_grade_in   = (status_next == STATUS_OK) ? grade_next : '0;
         end else begin
            byte_count_in  = count_next;
            running_crc_in = crc_next;
            header_ok_in   = header_next;
            speed_hold_in  = speed_next;
            grade_hold_in  = grade_next;
            crc_hold_in    = hold_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEVICE_ADDRESS_RESET;
         function_code_ff  <= FUNCTION_CODE_RESET;
         byte_count_ff     <= '0;
         running_crc_ff    <= CRC_INIT;
         header_ok_ff      <= 1'b1;
         speed_hold_ff     <= '0;
         grade_hold_ff     <= '0;
         crc_hold_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         device_address_ff <= device_address_in;
         function_code_ff  <= function_code_in;
         byte_count_ff     <= byte_count_in;
         running_crc_ff    <= running_crc_in;
         header_ok_ff      <= header_ok_in;
         speed_hold_ff     <= speed_hold_in;
         grade_hold_ff     <= grade_hold_in;
         crc_hold_ff       <= crc_hold_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_speed_ff  <= rsp_speed_in;
      rsp_grade_ff  <= rsp_grade_in;
   end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the Modbus response frame checker: directed frames, then random.
`timescale 1ns / 1ps

module tb_top;
   import mrfc_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 120;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_TOP = '1;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] speed;
      logic [WORD_W-1:0] grade;
   } frame_result_type;

   typedef struct packed {
      logic [BYTE_W-1:0] address;
      logic [BYTE_W-1:0] function_code;
      logic [WORD_W-1:0] speed;
      logic [WORD_W-1:0] grade;
      logic [WORD_W-1:0] crc_flip;
      logic [4:0]        length;
      logic              mid_write;
      logic [BYTE_W-1:0] mid_function;
      logic              typed;
      frame_result_type  expected;
   } frame_case_type;

   localparam int DIRECTED_COUNT = 15;
   localparam frame_case_type DIRECTED_FRAMES [DIRECTED_COUNT] = '{
      '{8'h01, 8'h03, 16'h0000, 16'hFFFF, 16'h0000, 5'd9,  1'b0, 8'h00, 1'b1,
        '{STATUS_OK, 16'h0000, 16'hFFFF}},
      '{8'h01, 8'h03, 16'hFFFF, 16'h0000, 16'h0000, 5'd9,  1'b0, 8'h00, 1'b1,
        '{STATUS_OK, 16'hFFFF, 16'h0000}},
      '{8'hFF, 8'h03, 16'h0000, 16'h0000, 16'h0000, 5'd1,  1'b0, 8'h00, 1'b1,
        '{STATUS_LENGTH, 16'h0000, 16'h0000}},
      '{8'h00, 8'h03, 16'h0000, 16'h0000, 16'h0000, 5'd1,  1'b0, 8'h00, 1'b1,
        '{STATUS_LENGTH, 16'h0000, 16'h0000}},
      '{8'h01, 8'h03, 16'h1111, 16'h2222, 16'h0000, 5'd8,  1'b0, 8'h00, 1'b1,
        '{STATUS_LENGTH, 16'h0000, 16'h0000}},
      '{8'h01, 8'h03, 16'h1111, 16'h2222, 16'h0000, 5'd17, 1'b0, 8'h00, 1'b1,
        '{STATUS_LENGTH, 16'h0000, 16'h0000}},
      '{8'h02, 8'h03, 16'h1111, 16'h2222, 16'h0000, 5'd8,  1'b0, 8'h00, 1'b1,
        '{STATUS_LENGTH, 16'h0000, 16'h0000}},
      '{8'h02, 8'h03, 16'h1111, 16'h2222, 16'h0000, 5'd9,  1'b0, 8'h00, 1'b1,
        '{STATUS_HEADER, 16'h0000, 16'h0000}},
      '{8'h01, 8'h04, 16'h1111, 16'h2222, 16'h0000, 5'd9,  1'b0, 8'h00, 1'b1,
        '{STATUS_HEADER, 16'h0000, 16'h0000}},
      '{8'h02, 8'h03, 16'h1111, 16'h2222, 16'h0001, 5'd9,  1'b0, 8'h00, 1'b1,
        '{STATUS_HEADER, 16'h0000, 16'h0000}},
      '{8'h01, 8'h03, 16'h1111, 16'h2222, 16'h0001, 5'd9,  1'b0, 8'h00, 1'b1,
        '{STATUS_CRC, 16'h0000, 16'h0000}},
      '{8'h01, 8'h03, 16'hABCD, 16'h00FF, 16'h8000, 5'd9,  1'b0, 8'h00, 1'b1,
        '{STATUS_CRC, 16'h0000, 16'h0000}},
      '{8'h00, 8'hFF, 16'h1111, 16'h2222, 16'h0000, 5'd9,  1'b0, 8'h00, 1'b1,
        '{STATUS_HEADER, 16'h0000, 16'h0000}},
      '{8'h01, 8'h10, 16'h1234, 16'h5678, 16'h0000, 5'd9,  1'b1, 8'h10, 1'b0,
        '{STATUS_OK, 16'h0000, 16'h0000}},
      '{8'h01, 8'h03, 16'h1234, 16'h5678, 16'h0000, 5'd9,  1'b0, 8'h00, 1'b1,
        '{STATUS_HEADER, 16'h0000, 16'h0000}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrfc_req_if req_ch ();
   mrfc_rsp_if rsp_ch ();
   mrfc_csr_if csr_ch ();

   modbus_response_frame_checker i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   logic [BYTE_W-1:0]  cfg_address;
   logic [BYTE_W-1:0]  cfg_function;
   logic [COUNT_W-1:0] seen_count;
   logic [WORD_W-1:0]  crc_acc;
   logic               header_match;
   logic [WORD_W-1:0]  speed_acc;
   logic [WORD_W-1:0]  grade_acc;
   logic [WORD_W-1:0]  crc_rx;

   frame_result_type  result_queue [$];
   frame_result_type  oldest;
   logic [BYTE_W-1:0] frame_octets [$];
   int                mismatch_count = 0;
   int                gap_pct = 0;
   int                stall_pct = 0;
   bit                hold_request = 1'b0;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] crc16_step(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] octet);
      logic [WORD_W-1:0] acc;
      acc = crc ^ WORD_W'(octet);
      repeat (BYTE_W) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      return acc;
   endfunction

   function automatic void clear_frame();
      seen_count   = '0;
      crc_acc      = CRC_INIT;
      header_match = 1'b1;
      speed_acc    = '0;
      grade_acc    = '0;
      crc_rx       = '0;
   endfunction

   function automatic bit absorb_octet(input logic [BYTE_W-1:0] octet, input logic last,
                                       output frame_result_type res);
      status_type verdict;
      res = '0;
      if ((seen_count == POS_ADDRESS && octet != cfg_address) ||
          (seen_count == POS_FUNCTION && octet != cfg_function)) begin
         header_match = 1'b0;
      end
      if (seen_count < CRC_SPAN) begin
         crc_acc = crc16_step(crc_acc, octet);
      end
      case (seen_count)
         POS_SPEED_HI: speed_acc[15:8] = octet;
         POS_SPEED_LO: speed_acc[7:0]  = octet;
         POS_GRADE_HI: grade_acc[15:8] = octet;
         POS_GRADE_LO: grade_acc[7:0]  = octet;
         POS_CRC_LO:   crc_rx[7:0]     = octet;
         POS_CRC_HI:   crc_rx[15:8]    = octet;
         default: ;
      endcase
      if (seen_count != COUNT_MAX) begin
         seen_count = seen_count + COUNT_W'(1);
      end
      if (!last) begin
         return 1'b0;
      end
      if (seen_count != FRAME_BYTES) begin
         verdict = STATUS_LENGTH;
      end else if (!header_match) begin
         verdict = STATUS_HEADER;
      end else if (crc_acc != crc_rx) begin
         verdict = STATUS_CRC;
      end else begin
         verdict = STATUS_OK;
      end
      res.status = verdict;
      if (verdict == STATUS_OK) begin
         res.speed = speed_acc;
         res.grade = grade_acc;
      end
      clear_frame();
      return 1'b1;
   endfunction

   function automatic void note_mismatch(input string msg);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
      mismatch_count++;
   endfunction

   function automatic void build_frame(input logic [BYTE_W-1:0] address, func_code, count,
                                       input logic [WORD_W-1:0] speed, grade, crc_flip,
                                       input int unsigned length);
      logic [WORD_W-1:0] crc;
      frame_octets = '{address, func_code, count, speed[15:8], speed[7:0],
                       grade[15:8], grade[7:0]};
      crc = CRC_INIT;
      foreach (frame_octets[i]) crc = crc16_step(crc, frame_octets[i]);
      crc ^= crc_flip;
      frame_octets.push_back(crc[7:0]);
      frame_octets.push_back(crc[15:8]);
      while (frame_octets.size() > length) frame_octets.pop_back();
      while (frame_octets.size() < length) frame_octets.push_back(BYTE_W'($urandom));
   endfunction

   task automatic quiesce();
      req_ch.valid <= 1'b0;
      while (result_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [BYTE_W-1:0] value,
                            input bit more);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (!more) begin
         csr_ch.valid <= 1'b0;
      end
      if (index == CSR_DEVICE_ADDRESS) begin
         cfg_address = value;
      end else if (index == CSR_FUNCTION_CODE) begin
         cfg_function = value;
      end
   endtask

   task automatic push_octet(input logic [BYTE_W-1:0] octet, input logic last,
                             input logic typed, input frame_result_type typed_result);
      frame_result_type predicted;
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.rx_byte   <= octet;
      req_ch.frame_end <= last;
      do @(posedge clock); while (!req_ch.ready);
      if (absorb_octet(octet, last, predicted)) begin
         result_queue.push_back(typed ? typed_result : predicted);
      end
   endtask

   task automatic send_frame(input logic mid_write, input logic [BYTE_W-1:0] mid_function,
                             input logic typed, input frame_result_type typed_result);
      for (int i = 0; i < frame_octets.size(); i++) begin
         push_octet(frame_octets[i], i == frame_octets.size() - 1, typed, typed_result);
         if (mid_write && i == 0) begin
            quiesce();
            write_reg(CSR_FUNCTION_CODE, mid_function, 1'b0);
         end
      end
   endtask

   task automatic send_random_frame();
      int unsigned       pick;
      int unsigned       length;
      logic [BYTE_W-1:0] address;
      logic [BYTE_W-1:0] func_code;
      logic [WORD_W-1:0] crc_flip;
      pick      = $urandom_range(0, 99);
      length    = 9;
      address   = cfg_address;
      func_code = cfg_function;
      crc_flip  = '0;
      if (pick >= 60 && pick < 68) begin
         address = BYTE_W'($urandom);
      end else if (pick >= 68 && pick < 76) begin
         func_code = BYTE_W'($urandom);
      end else if (pick >= 76 && pick < 84) begin
         crc_flip = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      end else if (pick >= 84 && pick < 94) begin
         length = $urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom_range(8, 10);
      end else if (pick >= 94) begin
         length = $urandom_range(1, 12);
      end
      build_frame(address, func_code, BYTE_W'($urandom), WORD_W'($urandom),
                  WORD_W'($urandom), crc_flip, length);
      if (pick >= 94) begin
         foreach (frame_octets[i]) frame_octets[i] = BYTE_W'($urandom);
      end
      send_frame(1'b0, '0, 1'b0, '0);
   endtask

   task automatic run_phase(input logic [BYTE_W-1:0] address, func_code,
                            input int gap, stall, frames, input bit hold);
      quiesce();
      write_reg(CSR_DEVICE_ADDRESS, address, 1'b1);
      write_reg(CSR_FUNCTION_CODE, func_code, 1'b0);
      gap_pct   = gap;
      stall_pct = stall;
      if (hold) begin
         hold_request = 1'b1;
      end
      repeat (frames) send_random_frame();
   endtask

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.rx_byte   <= '0;
      req_ch.frame_end <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= '0;
      csr_ch.data      <= '0;
      cfg_address  = DEVICE_ADDRESS_RESET;
      cfg_function = FUNCTION_CODE_RESET;
      clear_frame();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         build_frame(DIRECTED_FRAMES[i].address, DIRECTED_FRAMES[i].function_code, 8'h04,
                     DIRECTED_FRAMES[i].speed, DIRECTED_FRAMES[i].grade,
                     DIRECTED_FRAMES[i].crc_flip, DIRECTED_FRAMES[i].length);
         send_frame(DIRECTED_FRAMES[i].mid_write, DIRECTED_FRAMES[i].mid_function,
                    DIRECTED_FRAMES[i].typed, DIRECTED_FRAMES[i].expected);
      end

      run_phase(DEVICE_ADDRESS_RESET, FUNCTION_CODE_RESET, 0, 0, 25, 1'b0);
      quiesce();
      write_reg(CSR_UNUSED_LOW, 8'h5A, 1'b1);
      write_reg(CSR_UNUSED_TOP, 8'hA5, 1'b0);
      run_phase(8'h00, 8'h00, 30, 30, 35, 1'b0);
      run_phase(8'hFF, 8'hFF, 10, 40, 30, 1'b1);
      run_phase(BYTE_W'($urandom), BYTE_W'($urandom), 50, 15, 30, 1'b0);
      run_phase(BYTE_W'($urandom), BYTE_W'($urandom), 0, 0, 20, 1'b0);
      quiesce();

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      rsp_ch.ready <= 1'b1;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            // hold the receiver off while the sender keeps offering
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (result_queue.size() == 0) begin
            note_mismatch($sformatf("unexpected result: status %0d speed %h grade %h",
                                    rsp_ch.status, rsp_ch.wind_speed, rsp_ch.wind_level));
         end else begin
            oldest = result_queue.pop_front();
            if (rsp_ch.status !== oldest.status || rsp_ch.wind_speed !== oldest.speed ||
                rsp_ch.wind_level !== oldest.grade) begin
               note_mismatch($sformatf(
                  "expected status %0d speed %h grade %h, got status %0d speed %h grade %h",
                  oldest.status, oldest.speed, oldest.grade,
                  rsp_ch.status, rsp_ch.wind_speed, rsp_ch.wind_level));
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
src/mrfc_pkg.sv
src/mrfc_if.sv
src/modbus_response_frame_checker.sv
dv/tb_top.sv
